FILE: design/abpc_pkg.sv
// Shared constants, codes and the CRC-32 byte update for the aligned blob packer.
package abpc_pkg;

  // Field widths fixed by the record format
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned ID_W     = 32;
  localparam int unsigned REC_OFF_W = 48;
  localparam int unsigned REC_SZ_W  = 32;
  localparam int unsigned CRC_W    = 32;
  localparam int unsigned PAD_W    = 16;
  localparam int unsigned ERR_W    = 2;
  localparam int unsigned SHIFT_W  = 5;

  // Alignment register
  localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_RESET = 5'd12;
  localparam logic [SHIFT_W-1:0] ALIGN_SHIFT_MAX   = 5'd16;

  // Reflected CRC-32
  localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

  // Record error codes
  localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
  localparam logic [ERR_W-1:0] ERR_OFFSET   = 2'd1;
  localparam logic [ERR_W-1:0] ERR_SIZE_SAT = 2'd2;

  typedef logic [CRC_W-1:0] crc_t;

  // Fold one byte into the running CRC, LSB first
  function automatic crc_t crc_byte(input crc_t crc_in, input logic [DATA_W-1:0] b);
    crc_t c;
    c = crc_in ^ {{(CRC_W-DATA_W){1'b0}}, b};
    for (int k = 0; k < DATA_W; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {CRC_W{c[0]}});
    end
    return c;
  endfunction

endpackage

FILE: design/aligned_blob_packer_crc32_unit.sv
// Aligned blob packer: places blobs in a flat byte space and emits one CRC-32 record per blob.
//
//  channel | ports                                   | dir | handshake
//  --------+-----------------------------------------+-----+----------------------
//  in      | in_data_byte, in_last_byte, in_*_id      | in  | in_valid / in_ready
//  out     | out_rec_*, out_blob_*, out_pad_bytes,    | out | out_valid / out_ready
//          | out_error_code                          |     |
//  cfg     | cfg_data (align_shift)                  | in  | cfg_valid / cfg_ready
//
// One byte per cycle while nothing stalls: a request lands in the input register, is processed
// from there and, on a blob's last byte, its record is loaded into the output register.
// The aligned start of the next blob is precomputed from the cursor into a register, so the
// first byte of a blob waits while that register is stale after the previous record and
// after a configuration write.
// A stalled output holds its record; bytes keep entering while out_ready is high.
// Reset (synchronous, rst_n low) clears the cursor, the in-blob flag and both valids, and restores the shift.
module aligned_blob_packer_crc32_unit #(
  parameter int unsigned OFFSET_BITS = 48,
  parameter int unsigned SIZE_BITS   = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // byte stream
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [abpc_pkg::DATA_W-1:0]    in_data_byte,
  input  logic                          in_last_byte,
  input  logic [abpc_pkg::ID_W-1:0]      in_layer_id,
  input  logic [abpc_pkg::ID_W-1:0]      in_expert_id,
  // records
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [abpc_pkg::ID_W-1:0]      out_rec_layer,
  output logic [abpc_pkg::ID_W-1:0]      out_rec_expert,
  output logic [abpc_pkg::REC_OFF_W-1:0] out_blob_offset,
  output logic [abpc_pkg::REC_SZ_W-1:0]  out_blob_size,
  output logic [abpc_pkg::CRC_W-1:0]     out_blob_crc,
  output logic [abpc_pkg::PAD_W-1:0]     out_pad_bytes,
  output logic [abpc_pkg::ERR_W-1:0]     out_error_code,
  // alignment register
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [abpc_pkg::SHIFT_W-1:0]   cfg_data
);
  import abpc_pkg::*;

  localparam logic [OFFSET_BITS-1:0] OFF_MAX = {OFFSET_BITS{1'b1}};

  // configuration
  logic [SHIFT_W-1:0]     shift_r;

  // input register
  logic                   in_valid_r;
  logic [DATA_W-1:0]      data_r;
  logic                   last_r;
  logic [ID_W-1:0]        layer_r;
  logic [ID_W-1:0]        expert_r;

  // cursor and precomputed aligned start
  logic [OFFSET_BITS-1:0] cursor_r;
  logic [OFFSET_BITS-1:0] cand_r;
  logic [OFFSET_BITS-1:0] cand_nxt;
  logic                   cand_err_r;
  logic                   cand_err_nxt;
  logic                   cand_ok_r;
  logic [OFFSET_BITS-1:0] am1;
  logic [SHIFT_W-1:0]     sh;
  logic [OFFSET_BITS:0]   align_sum;

  // blob state
  logic                   inside_r;
  logic [OFFSET_BITS-1:0] start_r;
  logic [SIZE_BITS-1:0]   cnt_r;
  logic [OFFSET_BITS-1:0] end_r;
  logic                   end_ovf_r;
  logic [ERR_W-1:0]       err_r;
  crc_t                   crc_r;
  logic [PAD_W-1:0]       pad_r;

  // processing stage
  logic                   proc_go;
  logic                   first;
  logic [OFFSET_BITS-1:0] start_sel;
  logic [SIZE_BITS-1:0]   cnt_base;
  logic [OFFSET_BITS-1:0] end_base;
  logic                   ovf_base;
  logic [ERR_W-1:0]       err_base;
  crc_t                   crc_base;
  logic [PAD_W-1:0]       pad_base;
  logic                   cnt_sat;
  logic [SIZE_BITS-1:0]   cnt_nxt;
  logic [OFFSET_BITS-1:0] end_nxt;
  logic                   ovf_nxt;
  logic [ERR_W-1:0]       err_nxt;
  logic [ERR_W-1:0]       err_final;
  crc_t                   crc_nxt;
  logic [63:0]            off_ext;
  logic [63:0]            size_ext;

  // output register
  logic                   out_valid_r;
  logic [ID_W-1:0]        rec_layer_r;
  logic [ID_W-1:0]        rec_expert_r;
  logic [REC_OFF_W-1:0]   blob_offset_r;
  logic [REC_SZ_W-1:0]    blob_size_r;
  logic [CRC_W-1:0]       blob_crc_r;
  logic [PAD_W-1:0]       pad_bytes_r;
  logic [ERR_W-1:0]       error_code_r;

  // Handshakes
  assign cfg_ready = 1'b1;
  assign proc_go   = in_valid_r && (!out_valid_r || out_ready) && (inside_r || cand_ok_r);
  assign in_ready  = !in_valid_r || proc_go;

  // Round the cursor up to the alignment; a carry out means no room
  always_comb begin
    sh = (shift_r > ALIGN_SHIFT_MAX) ? ALIGN_SHIFT_MAX : shift_r;
    for (int i = 0; i < OFFSET_BITS; i++) begin
      am1[i] = (i < int'(sh));
    end
    align_sum    = {1'b0, cursor_r} + {1'b0, am1};
    cand_err_nxt = align_sum[OFFSET_BITS];
    cand_nxt     = cand_err_nxt ? cursor_r : (align_sum[OFFSET_BITS-1:0] & ~am1);
  end

  // Fold one byte into the blob state
  always_comb begin
    first     = !inside_r;
    start_sel = first ? cand_r : start_r;
    cnt_base  = first ? '0 : cnt_r;
    end_base  = first ? cand_r : end_r;
    ovf_base  = first ? 1'b0 : end_ovf_r;
    err_base  = first ? (cand_err_r ? ERR_OFFSET : ERR_NONE) : err_r;
    crc_base  = first ? CRC_INIT : crc_r;
    pad_base  = first ? (cand_r[PAD_W-1:0] - cursor_r[PAD_W-1:0]) : pad_r;

    crc_nxt = crc_byte(crc_base, data_r);

    // saturate the count and latch the size error
    cnt_sat = &cnt_base;
    cnt_nxt = cnt_sat ? cnt_base : cnt_base + 1'b1;
    err_nxt = (cnt_sat && err_base == ERR_NONE) ? ERR_SIZE_SAT : err_base;

    // track start plus count, pinned at the top of the offset space
    end_nxt = end_base;
    ovf_nxt = ovf_base;
    if (!cnt_sat) begin
      if (end_base == OFF_MAX) begin
        ovf_nxt = 1'b1;
      end else begin
        end_nxt = end_base + 1'b1;
      end
    end

    err_final = (err_nxt == ERR_NONE && ovf_nxt) ? ERR_OFFSET : err_nxt;
    off_ext   = 64'(start_sel);
    size_ext  = 64'(cnt_nxt);
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= ALIGN_SHIFT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      shift_r <= cfg_data;
    end
  end

  // Input register: take a request whenever the slot frees up
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r   <= in_data_byte;
      last_r   <= in_last_byte;
      layer_r  <= in_layer_id;
      expert_r <= in_expert_id;
    end
  end

  // Precomputed start: marked stale after the cursor or the shift moves, until it is registered anew
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_ok_r <= 1'b0;
    end else begin
      cand_ok_r <= !(proc_go && last_r) && !(cfg_valid && cfg_ready);
    end
  end

  always_ff @(posedge clk) begin
    cand_r     <= cand_nxt;
    cand_err_r <= cand_err_nxt;
  end

  // Cursor and blob tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= '0;
      inside_r <= 1'b0;
    end else if (proc_go) begin
      inside_r <= !last_r;
      if (last_r) begin
        cursor_r <= end_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go) begin
      start_r   <= start_sel;
      cnt_r     <= cnt_nxt;
      end_r     <= end_nxt;
      end_ovf_r <= ovf_nxt;
      err_r     <= err_nxt;
      crc_r     <= crc_nxt;
      pad_r     <= pad_base;
    end
  end

  // Output register: load a record on a last byte, drop valid once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_go && last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_go && last_r) begin
      rec_layer_r   <= layer_r;
      rec_expert_r  <= expert_r;
      blob_offset_r <= off_ext[REC_OFF_W-1:0];
      blob_size_r   <= size_ext[REC_SZ_W-1:0];
      blob_crc_r    <= ~crc_nxt;
      pad_bytes_r   <= pad_base;
      error_code_r  <= err_final;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rec_layer   = rec_layer_r;
  assign out_rec_expert  = rec_expert_r;
  assign out_blob_offset = blob_offset_r;
  assign out_blob_size   = blob_size_r;
  assign out_blob_crc    = blob_crc_r;
  assign out_pad_bytes   = pad_bytes_r;
  assign out_error_code  = error_code_r;

endmodule

FILE: design/abpc_checker.sv
// Port-level checks for the aligned blob packer, bound to the top level.
module abpc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [abpc_pkg::REC_OFF_W-1:0] out_blob_offset,
  input logic [abpc_pkg::REC_SZ_W-1:0]  out_blob_size,
  input logic [abpc_pkg::CRC_W-1:0]     out_blob_crc,
  input logic [abpc_pkg::ERR_W-1:0]     out_error_code
);
  import abpc_pkg::*;

  // Hold a stalled record
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_blob_offset)
      && $stable(out_blob_size) && $stable(out_blob_crc) && $stable(out_error_code))
    else $error("record changed while stalled");

  // Report only defined error codes
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_error_code == ERR_NONE || out_error_code == ERR_OFFSET
      || out_error_code == ERR_SIZE_SAT))
    else $error("undefined error code");

  // Every blob holds at least one byte
  a_size_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_blob_size != '0)
    else $error("empty blob record");

  // Reset drops the record
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("record valid after reset");

endmodule

bind aligned_blob_packer_crc32_unit abpc_checker u_abpc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_blob_offset (out_blob_offset),
  .out_blob_size   (out_blob_size),
  .out_blob_crc    (out_blob_crc),
  .out_error_code  (out_error_code)
);

FILE: sim/tb.sv
// Testbench for the aligned blob packer: directed table and random blob phases.
`timescale 1ns / 100ps

module tb;
  import abpc_pkg::*;

  // Offset and size counters at their default widths
  localparam int unsigned OFF_BITS = 48;
  localparam int unsigned SZ_BITS  = 32;
  localparam logic [63:0] OFF_MAX  = (64'd1 << OFF_BITS) - 64'd1;
  localparam logic [63:0] SZ_MAX   = (64'd1 << SZ_BITS) - 64'd1;

  localparam int unsigned RAND_PHASES  = 8;
  localparam int unsigned PHASE_BYTES  = 75;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  typedef struct packed {
    logic [ID_W-1:0]      layer;
    logic [ID_W-1:0]      expert;
    logic [REC_OFF_W-1:0] offset;
    logic [REC_SZ_W-1:0]  size;
    logic [CRC_W-1:0]     crc;
    logic [PAD_W-1:0]     pad;
    logic [ERR_W-1:0]     err;
  } blob_rec_t;

  typedef enum logic {ROW_CFG, ROW_BLOB} row_kind_e;

  // One row: an alignment write, or a whole blob of count bytes starting at val
  // (ramping by one per byte when ramp is set). Typed rows carry their record.
  typedef struct packed {
    row_kind_e   kind;
    logic [7:0]  val;
    logic [15:0] count;
    logic        ramp;
    logic [31:0] layer;
    logic [31:0] expert;
    logic        typed;
    blob_rec_t   want;
  } dir_row_t;

  localparam dir_row_t DIR_ROWS [14] = '{
    // after reset: cursor 0, alignment 4096
    '{ROW_BLOB, 8'h00, 16'd1, 1'b0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{32'h0000_0000, 32'h0000_0000, 48'd0, 32'd1, 32'hD202_EF8D, 16'd0, ERR_NONE}},
    '{ROW_BLOB, 8'hFF, 16'd1, 1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'd4096, 32'd1, 32'hFF00_0000, 16'd4095, ERR_NONE}},
    // check string "123456789"
    '{ROW_BLOB, 8'h31, 16'd9, 1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 1'b1,
      '{32'h1234_5678, 32'h9ABC_DEF0, 48'd8192, 32'd9, 32'hCBF4_3926, 16'd4095, ERR_NONE}},
    '{ROW_CFG,  8'd0,  16'd0, 1'b0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_BLOB, 8'hA5, 16'd2, 1'b1, 32'h0000_0001, 32'h0000_0002, 1'b0, '0},
    // shift above the maximum acts as 65536-byte alignment
    '{ROW_CFG,  8'd31, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_BLOB, 8'hFF, 16'd1, 1'b0, 32'h8000_0000, 32'h0000_0001, 1'b1,
      '{32'h8000_0000, 32'h0000_0001, 48'd65536, 32'd1, 32'hFF00_0000, 16'd57333, ERR_NONE}},
    '{ROW_CFG,  8'd16, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_BLOB, 8'h5A, 16'd3, 1'b0, 32'hCAFE_0001, 32'h0000_FFFF, 1'b0, '0},
    '{ROW_CFG,  8'd1,  16'd0, 1'b0, 32'h0, 32'h0, 1'b0, '0},
    // long ramps that run the byte value through its whole range
    '{ROW_BLOB, 8'h00, 16'd256, 1'b1, 32'h0000_00AA, 32'h0000_0055, 1'b0, '0},
    '{ROW_BLOB, 8'h01, 16'd255, 1'b1, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
    '{ROW_CFG,  8'd12, 16'd0, 1'b0, 32'h0, 32'h0, 1'b0, '0},
    '{ROW_BLOB, 8'hC3, 16'd1, 1'b0, 32'h0F0F_0F0F, 32'hF0F0_F0F0, 1'b0, '0}
  };

  logic                 clk          = 1'b0;
  logic                 rst_n        = 1'b0;
  logic                 in_valid     = 1'b0;
  logic [DATA_W-1:0]    in_data_byte = '0;
  logic                 in_last_byte = 1'b0;
  logic [ID_W-1:0]      in_layer_id  = '0;
  logic [ID_W-1:0]      in_expert_id = '0;
  logic                 out_ready    = 1'b0;
  logic                 cfg_valid    = 1'b0;
  logic [SHIFT_W-1:0]   cfg_data     = '0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  logic [ID_W-1:0]      out_rec_layer;
  logic [ID_W-1:0]      out_rec_expert;
  logic [REC_OFF_W-1:0] out_blob_offset;
  logic [REC_SZ_W-1:0]  out_blob_size;
  logic [CRC_W-1:0]     out_blob_crc;
  logic [PAD_W-1:0]     out_pad_bytes;
  logic [ERR_W-1:0]     out_error_code;

  aligned_blob_packer_crc32_unit #(
    .OFFSET_BITS(OFF_BITS),
    .SIZE_BITS  (SZ_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_data_byte   (in_data_byte),
    .in_last_byte   (in_last_byte),
    .in_layer_id    (in_layer_id),
    .in_expert_id   (in_expert_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rec_layer  (out_rec_layer),
    .out_rec_expert (out_rec_expert),
    .out_blob_offset(out_blob_offset),
    .out_blob_size  (out_blob_size),
    .out_blob_crc   (out_blob_crc),
    .out_pad_bytes  (out_pad_bytes),
    .out_error_code (out_error_code),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Run the clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Packer state as predicted from the accepted byte stream
  logic [SHIFT_W-1:0] pk_shift  = ALIGN_SHIFT_RESET;
  logic [63:0]        pk_cursor = '0;
  logic [63:0]        pk_start  = '0;
  logic [63:0]        pk_count  = '0;
  crc_t               pk_crc    = CRC_INIT;
  logic               pk_open   = 1'b0;
  logic [ERR_W-1:0]   pk_err    = ERR_NONE;

  blob_rec_t   records_due[$];
  int unsigned fail_count   = 0;
  int unsigned recs_checked = 0;
  int unsigned bytes_sent   = 0;
  int unsigned cfg_writes   = 0;
  int unsigned err_records  = 0;
  int unsigned cycle_count  = 0;
  int unsigned snd_idle     = 0;
  int unsigned rcv_stall    = 0;
  int unsigned hold_asks    = 0;
  int unsigned hold_seen    = 0;
  int unsigned hold_left    = 0;

  function automatic crc_t crc_fold(input crc_t c, input logic [7:0] d);
    crc_t r;
    r = c ^ {24'd0, d};
    repeat (8) r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    return r;
  endfunction

  // Keep the first error of a blob
  task automatic latch_err(input logic [ERR_W-1:0] code);
    if (pk_err == ERR_NONE) pk_err = code;
  endtask

  // Advance the packer by one accepted byte; emit a record on the last byte
  task automatic place_byte(input logic [7:0] d, input logic last,
                            input logic [31:0] layer, input logic [31:0] expert,
                            output logic made, output blob_rec_t rec);
    logic [63:0]        cur;
    logic [63:0]        am1;
    logic [63:0]        fin;
    logic [SHIFT_W-1:0] sh;
    cur  = pk_cursor & OFF_MAX;
    made = 1'b0;
    rec  = '0;
    if (!pk_open) begin
      sh  = (pk_shift > ALIGN_SHIFT_MAX) ? ALIGN_SHIFT_MAX : pk_shift;
      am1 = (64'd1 << sh) - 64'd1;
      if (cur > OFF_MAX - am1) begin
        pk_start = cur;
        latch_err(ERR_OFFSET);
      end else begin
        pk_start = ((cur + am1) & ~am1) & OFF_MAX;
      end
      pk_open = 1'b1;
    end
    pk_crc = crc_fold(pk_crc, d);
    if (pk_count >= SZ_MAX) begin
      pk_count = SZ_MAX;
      latch_err(ERR_SIZE_SAT);
    end else begin
      pk_count = pk_count + 64'd1;
    end
    if (last) begin
      if (pk_count > OFF_MAX - pk_start) begin
        fin = OFF_MAX;
        latch_err(ERR_OFFSET);
      end else begin
        fin = pk_start + pk_count;
      end
      made       = 1'b1;
      rec.layer  = layer;
      rec.expert = expert;
      rec.offset = pk_start[REC_OFF_W-1:0];
      rec.size   = pk_count[REC_SZ_W-1:0];
      rec.crc    = ~pk_crc;
      rec.pad    = PAD_W'(pk_start - cur);
      rec.err    = pk_err;
      pk_cursor  = fin;
      pk_count   = '0;
      pk_crc     = CRC_INIT;
      pk_open    = 1'b0;
      pk_err     = ERR_NONE;
    end
  endtask

  // Offer one byte request, hold it until accepted, then queue its record if any
  task automatic send_byte(input logic [7:0] d, input logic last,
                           input logic [31:0] layer, input logic [31:0] expert,
                           input logic typed, input blob_rec_t want);
    logic      hs;
    logic      made;
    blob_rec_t rec;
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= d;
    in_last_byte <= last;
    in_layer_id  <= layer;
    in_expert_id <= expert;
    hs = 1'b0;
    while (!hs) begin
      @(negedge clk);
      hs = (in_ready === 1'b1);
      @(posedge clk);
    end
    bytes_sent++;
    place_byte(d, last, layer, expert, made, rec);
    if (made) begin
      records_due = {records_due, (typed ? want : rec)};
      if (rec.err != ERR_NONE) err_records++;
    end
  endtask

  // Random blob of len bytes; ids on the earlier bytes are noise
  task automatic send_blob(input int unsigned len);
    logic [31:0] layer;
    logic [31:0] expert;
    layer  = $urandom;
    expert = $urandom;
    for (int unsigned k = 0; k < len; k++) begin
      if (k == len - 1) send_byte(8'($urandom), 1'b1, layer, expert, 1'b0, '0);
      else send_byte(8'($urandom), 1'b0, $urandom, $urandom, 1'b0, '0);
    end
  endtask

  // Drain, let the block settle, then write the alignment register
  task automatic write_align(input logic [SHIFT_W-1:0] v);
    logic hs;
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    hs = 1'b0;
    while (!hs) begin
      @(negedge clk);
      hs = (cfg_ready === 1'b1);
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    pk_shift = v;
    cfg_writes++;
  endtask

  task automatic report(input string msg);
    $display("ERROR: %s", msg);
    fail_count++;
  endtask

  task automatic cmp_field(input string name, input logic [63:0] got_v,
                           input logic [63:0] want_v);
    if (got_v !== want_v)
      report($sformatf("record %0d %s: got 0x%0h, expected 0x%0h",
                       recs_checked, name, got_v, want_v));
  endtask

  // Drive the receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_stall);
    end
  end

  // Check each record request against the oldest expected record
  always @(negedge clk) begin : rec_mon
    blob_rec_t want;
    if (rst_n && out_valid === 1'b1 && out_ready === 1'b1) begin
      if (records_due.size() == 0) begin
        report($sformatf("record with nothing expected: offset 0x%0h size %0d",
                         out_blob_offset, out_blob_size));
      end else begin
        want = records_due.pop_front();
        cmp_field("layer",  64'(out_rec_layer),   64'(want.layer));
        cmp_field("expert", 64'(out_rec_expert),  64'(want.expert));
        cmp_field("offset", 64'(out_blob_offset), 64'(want.offset));
        cmp_field("size",   64'(out_blob_size),   64'(want.size));
        cmp_field("crc",    64'(out_blob_crc),    64'(want.crc));
        cmp_field("pad",    64'(out_pad_bytes),   64'(want.pad));
        cmp_field("error",  64'(out_error_code),  64'(want.err));
      end
      recs_checked++;
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d records outstanding",
               cycle_count, records_due.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stim
    int unsigned n;
    int unsigned len;
    int unsigned r;
    logic        paused;
    paused = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (DIR_ROWS[i]) begin
      if (DIR_ROWS[i].kind == ROW_CFG) begin
        write_align(DIR_ROWS[i].val[SHIFT_W-1:0]);
      end else begin
        for (int unsigned k = 0; k < DIR_ROWS[i].count; k++) begin
          if (k == DIR_ROWS[i].count - 1)
            send_byte(DIR_ROWS[i].val + (DIR_ROWS[i].ramp ? 8'(k) : 8'd0), 1'b1,
                      DIR_ROWS[i].layer, DIR_ROWS[i].expert,
                      DIR_ROWS[i].typed, DIR_ROWS[i].want);
          else
            send_byte(DIR_ROWS[i].val + (DIR_ROWS[i].ramp ? 8'(k) : 8'd0), 1'b0,
                      ~DIR_ROWS[i].layer, ~DIR_ROWS[i].expert, 1'b0, '0);
        end
      end
    end

    // Random blobs, one alignment per phase, cycling through the idle patterns
    for (int unsigned ph = 0; ph < RAND_PHASES; ph++) begin
      case (ph % 4)
        0: begin snd_idle = 0;  rcv_stall = 0;  end
        1: begin snd_idle = 55; rcv_stall = 0;  end
        2: begin snd_idle = 0;  rcv_stall = 55; end
        default: begin snd_idle = 32; rcv_stall = 32; end
      endcase
      write_align(SHIFT_W'($urandom_range(31)));
      n = 0;
      while (n < PHASE_BYTES) begin
        // hold off the receiver while bytes keep coming
        if (ph == 1 && n >= 40 && hold_asks == 0) hold_asks++;
        // pause the sender until every record is out
        if (ph == 2 && n >= 60 && !paused) begin
          paused = 1'b1;
          in_valid <= 1'b0;
          @(posedge clk);
          while (records_due.size() != 0) @(posedge clk);
        end
        r = $urandom_range(99);
        if (r < 5) len = $urandom_range(64, 32);
        else if (r < 70) len = $urandom_range(4, 1);
        else len = $urandom_range(24, 5);
        send_blob(len);
        n += len;
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    @(posedge clk);
    while (records_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d records from %0d bytes across %0d alignment writes",
             recs_checked, bytes_sent, cfg_writes);
    $display("Records with an error code: %0d; cursor ended at 0x%0h", err_records, pk_cursor);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: aligned_blob_packer_crc32_unit.f
design/abpc_pkg.sv
design/aligned_blob_packer_crc32_unit.sv
design/abpc_checker.sv
sim/tb.sv
